@@ rtl/directional_light_shading_core_defines.svh @@
// Assertion macros used by the shading core RTL.
`ifndef DIRECTIONAL_LIGHT_SHADING_CORE_DEFINES_SVH
`define DIRECTIONAL_LIGHT_SHADING_CORE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define DLSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define DLSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/dlsc_pkg.sv @@
`default_nettype none
package dlsc_pkg;

  localparam int unsigned GainFracBits = 12;
  localparam int unsigned DirFracBits  = 14;
  localparam int unsigned AmbShift     = GainFracBits + DirFracBits;
  localparam int unsigned ScaleShift   = 2 * GainFracBits + 6;
  localparam int unsigned LenBits      = 16;
  localparam int unsigned DivBits      = 32;
  localparam int unsigned ScaleBits    = 22;
  localparam int unsigned SumBits      = 66;

  localparam logic signed [ScaleBits-1:0] ScaleMax = 22'sd1048576;
  localparam logic signed [ScaleBits-1:0] ScaleMin = -22'sd1048576;
  localparam logic [7:0] Darkest   = 8'd4;
  localparam logic [7:0] Brightest = 8'hFC;

  typedef enum logic [2:0] {
    CfgSunX    = 3'd0,
    CfgSunY    = 3'd1,
    CfgSunZ    = 3'd2,
    CfgFront   = 3'd3,
    CfgBack    = 3'd4,
    CfgTint    = 3'd5,
    CfgAmbient = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] sun_x;
    logic signed [15:0] sun_y;
    logic signed [15:0] sun_z;
    logic signed [15:0] front;
    logic signed [15:0] back;
    logic [23:0]        tint;
    logic signed [15:0] ambient;
  } cfg_t;

  typedef struct packed {
    logic [23:0]        colour;
    logic signed [15:0] strength;
  } carry_t;

  typedef struct packed {
    carry_t             carry;
    logic               neg;
    logic               zero;
    logic [DivBits-1:0] mag;
    logic [LenBits-1:0] len;
  } div_in_t;

  typedef struct packed {
    carry_t             carry;
    logic               neg;
    logic               zero;
    logic [DivBits-1:0] quo;
  } div_out_t;

  typedef struct packed {
    logic [23:0]                 colour;
    logic signed [ScaleBits-1:0] scale;
  } scale_out_t;

endpackage
`default_nettype wire

@@ rtl/dlsc_front.sv @@
`default_nettype none
module dlsc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dlsc_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [23:0]       base_colour_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic [15:0]       normal_length_i,
  input  logic signed [15:0] light_strength_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dlsc_pkg::div_in_t out_o
);
  import dlsc_pkg::*;

  logic               a_valid_q, b_valid_q;
  logic               a_ready, b_ready;
  logic signed [31:0] px_q, py_q, pz_q;
  carry_t             a_carry_q;
  logic [15:0]        a_len_q;
  logic signed [33:0] dot;
  div_in_t            b_d, b_q;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      px_q      <= cfg_i.sun_x * normal_x_i;
      py_q      <= cfg_i.sun_y * normal_y_i;
      pz_q      <= cfg_i.sun_z * normal_z_i;
      a_carry_q <= '{colour: base_colour_i, strength: light_strength_i};
      a_len_q   <= normal_length_i;
    end
  end

  always_comb begin
    dot         = 34'(px_q) + 34'(py_q) + 34'(pz_q);
    b_d.carry   = a_carry_q;
    b_d.neg     = dot[33];
    b_d.zero    = (a_len_q == '0);
    b_d.mag     = dot[33] ? 32'(-dot) : dot[31:0];
    b_d.len     = a_len_q;
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) b_q <= b_d;
  end

  assign out_valid_o = b_valid_q;
  assign out_o       = b_q;
endmodule
`default_nettype wire

@@ rtl/dlsc_div.sv @@
`default_nettype none
module dlsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dlsc_pkg::div_in_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dlsc_pkg::div_out_t out_o
);
  import dlsc_pkg::*;

  typedef struct packed {
    carry_t             carry;
    logic               neg;
    logic               zero;
    logic [LenBits-1:0] len;
    logic [LenBits-1:0] rem;
    logic [DivBits-1:0] num;
    logic [DivBits-1:0] quo;
  } div_st_t;

  div_st_t          st_q   [DivBits];
  div_st_t          prev_s [DivBits];
  div_st_t          next_s [DivBits];
  logic [DivBits-1:0] valid_q;
  logic [DivBits-1:0] prev_v;
  logic [DivBits:0]   ready;

  assign ready[DivBits] = out_ready_i;

  // One quotient bit per stage, restoring division.
  for (genvar k = 0; k < DivBits; k++) begin : g_stage
    logic [LenBits:0] shifted;
    logic             ge;

    if (k == 0) begin : g_first
      assign prev_s[k] = '{carry: in_i.carry, neg: in_i.neg, zero: in_i.zero, len: in_i.len,
                           rem: '0, num: in_i.mag, quo: '0};
      assign prev_v[k] = in_valid_i;
    end else begin : g_rest
      assign prev_s[k] = st_q[k-1];
      assign prev_v[k] = valid_q[k-1];
    end

    assign ready[k] = !valid_q[k] || ready[k+1];
    assign shifted  = {prev_s[k].rem, prev_s[k].num[DivBits-1]};
    assign ge       = (shifted >= {1'b0, prev_s[k].len});

    always_comb begin
      next_s[k]     = prev_s[k];
      next_s[k].rem = ge ? LenBits'(shifted - {1'b0, prev_s[k].len}) : shifted[LenBits-1:0];
      next_s[k].num = {prev_s[k].num[DivBits-2:0], 1'b0};
      next_s[k].quo = {prev_s[k].quo[DivBits-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (ready[k]) begin
        valid_q[k] <= prev_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[k] && prev_v[k]) st_q[k] <= next_s[k];
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[DivBits-1];
  assign out_o       = '{carry: st_q[DivBits-1].carry, neg: st_q[DivBits-1].neg,
                         zero: st_q[DivBits-1].zero, quo: st_q[DivBits-1].quo};
endmodule
`default_nettype wire

@@ rtl/dlsc_scale.sv @@
`default_nettype none
module dlsc_scale (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dlsc_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dlsc_pkg::div_out_t   in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dlsc_pkg::scale_out_t out_o
);
  import dlsc_pkg::*;

  logic [2:0]                 valid_q;
  logic [3:0]                 ready;
  logic signed [DivBits:0]    cos_d, cos_q;
  logic signed [15:0]         gain;
  logic signed [31:0]         gs_q;
  logic [23:0]                col1_q, col2_q;
  logic signed [64:0]         prod_q;
  logic signed [SumBits-1:0]  amb_ext, sum, shifted;
  scale_out_t                 s3_d, s3_q;

  assign ready[3] = out_ready_i;
  for (genvar k = 0; k < 3; k++) begin : g_ready
    assign ready[k] = !valid_q[k] || ready[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) valid_q[0] <= in_valid_i;
      if (ready[1]) valid_q[1] <= valid_q[0];
      if (ready[2]) valid_q[2] <= valid_q[1];
    end
  end

  always_comb begin
    if (in_i.zero) begin
      cos_d = '0;
    end else if (in_i.neg) begin
      cos_d = -$signed({1'b0, in_i.quo});
    end else begin
      cos_d = $signed({1'b0, in_i.quo});
    end
    // Front gain only for a strictly positive cosine.
    gain = (!in_i.zero && !in_i.neg && (in_i.quo != '0)) ? cfg_i.front : cfg_i.back;
  end

  always_ff @(posedge clk_i) begin
    if (ready[0] && in_valid_i) begin
      cos_q  <= cos_d;
      gs_q   <= gain * in_i.carry.strength;
      col1_q <= in_i.carry.colour;
    end
    if (ready[1] && valid_q[0]) begin
      prod_q <= gs_q * cos_q;
      col2_q <= col1_q;
    end
    if (ready[2] && valid_q[1]) s3_q <= s3_d;
  end

  always_comb begin
    amb_ext = SumBits'(cfg_i.ambient) <<< AmbShift;
    sum     = amb_ext + SumBits'(prod_q);
    shifted = sum >>> ScaleShift;
    s3_d.colour = col2_q;
    if (shifted > SumBits'(ScaleMax)) begin
      s3_d.scale = ScaleMax;
    end else if (shifted < SumBits'(ScaleMin)) begin
      s3_d.scale = ScaleMin;
    end else begin
      s3_d.scale = shifted[ScaleBits-1:0];
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[2];
  assign out_o       = s3_q;
endmodule
`default_nettype wire

@@ rtl/dlsc_shade.sv @@
`default_nettype none
module dlsc_shade (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dlsc_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dlsc_pkg::scale_out_t in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           lit_red_o,
  output logic [7:0]           lit_green_o,
  output logic [7:0]           lit_blue_o
);
  import dlsc_pkg::*;

  logic [2:0]                  valid_q;
  logic [3:0]                  ready;
  logic [7:0]                  tint_q [3];
  logic signed [ScaleBits-1:0] scale_q;
  logic signed [30:0]          mul_q  [3];
  logic [7:0]                  lit_d  [3];
  logic [7:0]                  lit_q  [3];

  assign ready[3] = out_ready_i;
  for (genvar k = 0; k < 3; k++) begin : g_ready
    assign ready[k] = !valid_q[k] || ready[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) valid_q[0] <= in_valid_i;
      if (ready[1]) valid_q[1] <= valid_q[0];
      if (ready[2]) valid_q[2] <= valid_q[1];
    end
  end

  // Channel 0 is red (bits 23..16), 2 is blue (bits 7..0).
  for (genvar c = 0; c < 3; c++) begin : g_chan
    localparam int unsigned Lsb = 16 - 8 * c;
    logic [15:0]        tinted;
    logic signed [22:0] floored;

    assign tinted  = in_i.colour[Lsb+:8] * cfg_i.tint[Lsb+:8];
    assign floored = 23'(mul_q[c] >>> 8);

    always_comb begin
      if (floored < 23'sd4) begin
        lit_d[c] = Darkest;
      end else if (floored > 23'sd252) begin
        lit_d[c] = Brightest;
      end else begin
        lit_d[c] = floored[7:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[0] && in_valid_i) tint_q[c] <= tinted[15:8];
      if (ready[1] && valid_q[0]) mul_q[c] <= scale_q * $signed({1'b0, tint_q[c]});
      if (ready[2] && valid_q[1]) lit_q[c] <= lit_d[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[0] && in_valid_i) scale_q <= in_i.scale;
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[2];
  assign lit_red_o   = lit_q[0];
  assign lit_green_o = lit_q[1];
  assign lit_blue_o  = lit_q[2];
endmodule
`default_nettype wire

@@ rtl/directional_light_shading_core.sv @@
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_stall_o  base_colour, normal_x/y/z, normal_length,
//                                            light_strength
// out       output     out_valid_o/out_stall_i lit_red, lit_green, lit_blue
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Throughput one item per cycle while out_stall_i is low; the pipeline runs through the dot product,
// the one-bit-per-stage length divider, gain and scale, then shading.
// Reset clears all stage valid bits and loads the register defaults.
// A stall holds the output register; empty stages upstream keep filling.
// cfg_ready_o is always high; write only while the pipeline is empty.
`default_nettype none
`include "directional_light_shading_core_defines.svh"
module directional_light_shading_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [23:0]        base_colour_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic [15:0]        normal_length_i,
  input  logic signed [15:0] light_strength_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         lit_red_o,
  output logic [7:0]         lit_green_o,
  output logic [7:0]         lit_blue_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);
  import dlsc_pkg::*;

  cfg_t       cfg_q;
  logic       front_ready, div_valid, div_ready, scale_valid, scale_ready;
  logic       shade_valid, shade_ready;
  div_in_t    div_in;
  div_out_t   div_out;
  scale_out_t scale_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sun_x   <= 16'sd0;
      cfg_q.sun_y   <= -16'sd16384;
      cfg_q.sun_z   <= 16'sd0;
      cfg_q.front   <= 16'sd4096;
      cfg_q.back    <= 16'sd4096;
      cfg_q.tint    <= 24'hFFFFFF;
      cfg_q.ambient <= 16'sd2048;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgSunX:    cfg_q.sun_x   <= cfg_data_i[15:0];
        CfgSunY:    cfg_q.sun_y   <= cfg_data_i[15:0];
        CfgSunZ:    cfg_q.sun_z   <= cfg_data_i[15:0];
        CfgFront:   cfg_q.front   <= cfg_data_i[15:0];
        CfgBack:    cfg_q.back    <= cfg_data_i[15:0];
        CfgTint:    cfg_q.tint    <= cfg_data_i;
        CfgAmbient: cfg_q.ambient <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  dlsc_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i, .in_ready_o(front_ready),
    .base_colour_i, .normal_x_i, .normal_y_i, .normal_z_i, .normal_length_i,
    .light_strength_i,
    .out_valid_o(div_valid), .out_ready_i(div_ready), .out_o(div_in)
  );

  dlsc_div u_div (
    .clk_i, .rst_ni,
    .in_valid_i(div_valid), .in_ready_o(div_ready), .in_i(div_in),
    .out_valid_o(scale_valid), .out_ready_i(scale_ready), .out_o(div_out)
  );

  dlsc_scale u_scale (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(scale_valid), .in_ready_o(scale_ready), .in_i(div_out),
    .out_valid_o(shade_valid), .out_ready_i(shade_ready), .out_o(scale_out)
  );

  dlsc_shade u_shade (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i(shade_valid), .in_ready_o(shade_ready), .in_i(scale_out),
    .out_valid_o, .out_ready_i(!out_stall_i),
    .lit_red_o, .lit_green_o, .lit_blue_o
  );

  assign in_stall_o = !front_ready;

  `DLSC_ASSERT_IMPL(a_out_range, out_valid_o,
    lit_red_o >= Darkest && lit_red_o <= Brightest &&
    lit_green_o >= Darkest && lit_green_o <= Brightest &&
    lit_blue_o >= Darkest && lit_blue_o <= Brightest, "result outside 4..252")
  `DLSC_ASSERT_IMPL(a_stall_backed, in_stall_o, out_valid_o && out_stall_i,
    "input stalled without a blocked result")
  `DLSC_ASSERT_IMPL(a_empty_out_ready, !out_valid_o, !in_stall_o,
    "input stalled while the output register is empty")
endmodule
`default_nettype wire

@@ tb/directional_light_shading_core_checker.sv @@
`timescale 1ns / 100ps
module directional_light_shading_core_checker
  import dlsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [23:0]        base_colour_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic [15:0]        normal_length_i,
  input  logic signed [15:0] light_strength_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [7:0]         lit_red_o,
  input  logic [7:0]         lit_green_o,
  input  logic [7:0]         lit_blue_o,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  output int unsigned        mismatch_count,
  output int unsigned        pending_count
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } lit_t;

  logic signed [15:0] sun_x, sun_y, sun_z, front_gain, back_gain, ambient;
  logic [23:0]        sun_tint;
  lit_t               lit_q[$];

  function automatic logic [7:0] shade_channel(longint scale, logic [7:0] c, logic [7:0] t);
    longint tinted;
    longint v;
    tinted = (longint'(c) * longint'(t)) >>> 8;
    v = (scale * tinted) >>> 8;
    if (v < longint'(Darkest)) return Darkest;
    if (v > longint'(Brightest)) return Brightest;
    return v[7:0];
  endfunction

  function automatic lit_t shade_vertex(logic [23:0] colour, logic signed [15:0] nx,
                                        logic signed [15:0] ny, logic signed [15:0] nz,
                                        logic [15:0] len, logic signed [15:0] strength);
    longint dot, mag, cos14, gain, sum, scale;
    lit_t   res;
    dot = longint'(sun_x) * longint'(nx) + longint'(sun_y) * longint'(ny)
        + longint'(sun_z) * longint'(nz);
    cos14 = 0;
    if (len != 0) begin
      mag = (dot < 0) ? -dot : dot;
      cos14 = mag / longint'({48'd0, len});
      if (dot < 0) cos14 = -cos14;
    end
    gain = (cos14 > 0) ? longint'(front_gain) : longint'(back_gain);
    sum = (longint'(ambient) <<< AmbShift) + gain * longint'(strength) * cos14;
    scale = sum >>> ScaleShift;
    if (scale > longint'(ScaleMax)) scale = longint'(ScaleMax);
    else if (scale < longint'(ScaleMin)) scale = longint'(ScaleMin);
    res.red   = shade_channel(scale, colour[23:16], sun_tint[23:16]);
    res.green = shade_channel(scale, colour[15:8], sun_tint[15:8]);
    res.blue  = shade_channel(scale, colour[7:0], sun_tint[7:0]);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lit_t got;
    lit_t want;
    if (!rst_ni) begin
      sun_x          <= 16'sd0;
      sun_y          <= -16'sd16384;
      sun_z          <= 16'sd0;
      front_gain     <= 16'sd4096;
      back_gain      <= 16'sd4096;
      sun_tint       <= 24'hFFFFFF;
      ambient        <= 16'sd2048;
      mismatch_count <= 0;
      pending_count  <= 0;
      lit_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgSunX:    sun_x      <= cfg_data_i[15:0];
          CfgSunY:    sun_y      <= cfg_data_i[15:0];
          CfgSunZ:    sun_z      <= cfg_data_i[15:0];
          CfgFront:   front_gain <= cfg_data_i[15:0];
          CfgBack:    back_gain  <= cfg_data_i[15:0];
          CfgTint:    sun_tint   <= cfg_data_i;
          CfgAmbient: ambient    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o)
        lit_q.push_back(shade_vertex(base_colour_i, normal_x_i, normal_y_i, normal_z_i,
                                     normal_length_i, light_strength_i));
      if (out_valid_o && !out_stall_i) begin
        got = '{red: lit_red_o, green: lit_green_o, blue: lit_blue_o};
        if (lit_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected transfer: r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = lit_q.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display("lit colour: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       want.red, want.green, want.blue, got.red, got.green, got.blue);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      pending_count <= lit_q.size();
    end
  end

endmodule

@@ tb/directional_light_shading_core_tb.sv @@
`timescale 1ns / 100ps
module directional_light_shading_core_tb;
  import dlsc_pkg::*;

  localparam logic [2:0] CfgUnused = 3'd7;
  localparam int unsigned PipeDepth = 40;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [23:0]        colour;
    logic signed [15:0] nx, ny, nz;
    logic [15:0]        len;
    logic signed [15:0] strength;
  } vertex_t;

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_stall_o;
  logic [23:0]        base_colour_i;
  logic signed [15:0] normal_x_i, normal_y_i, normal_z_i, light_strength_i;
  logic [15:0]        normal_length_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         lit_red_o, lit_green_o, lit_blue_o;
  logic               cfg_valid_i, cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [23:0]        cfg_data_i;
  int unsigned        mismatch_count, pending_count;
  int unsigned        cycle_count = 0;
  int unsigned        burst_left;
  int unsigned        stall_left = 0;
  int unsigned        stall_mode = 0;

  directional_light_shading_core u_top (.*);

  directional_light_shading_core_checker u_checker (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("directional_light_shading_core: mismatch");
      $finish;
    end
  end

  // Receiver stall pattern: free-flowing, light and heavy stretches.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(5, 60);
      stall_mode <= $urandom_range(0, 2);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 4) != 0);
    endcase
  end

  task automatic send_vertex(vertex_t v);
    int unsigned gap;
    in_valid_i       <= 1'b1;
    base_colour_i    <= v.colour;
    normal_x_i       <= v.nx;
    normal_y_i       <= v.ny;
    normal_z_i       <= v.nz;
    normal_length_i  <= v.len;
    light_strength_i <= v.strength;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    // upper bits are don't-care for 16-bit registers; toggle them anyway
    cfg_data_i  <= {8'($urandom), value};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic load_setting(logic signed [15:0] sx, logic signed [15:0] sy,
                              logic signed [15:0] sz, logic signed [15:0] front,
                              logic signed [15:0] back, logic [23:0] tint,
                              logic signed [15:0] amb);
    cfg_write(CfgSunX, sx);
    cfg_write(CfgSunY, sy);
    cfg_write(CfgSunZ, sz);
    cfg_write(CfgFront, front);
    cfg_write(CfgBack, back);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgTint;
    cfg_data_i  <= tint;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_write(CfgAmbient, amb);
    // index past the register list must be ignored
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgUnused;
    cfg_data_i  <= 24'($urandom);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (PipeDepth + 5) @(posedge clk_i);
  endtask

  function automatic int rand_comp(int amp);
    return int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  function automatic vertex_t make_vertex();
    vertex_t v;
    int      amp;
    int      x, y, z;
    real     r;
    v.colour = 24'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      // noise over the full field ranges
      v.nx = 16'($urandom);
      v.ny = 16'($urandom);
      v.nz = 16'($urandom);
      v.len = 16'($urandom);
      v.strength = 16'($urandom);
      return v;
    end
    case ($urandom_range(0, 3))
      0:       amp = 15;
      1:       amp = 255;
      2:       amp = 4095;
      default: amp = 32767;
    endcase
    x = rand_comp(amp);
    y = rand_comp(amp);
    z = rand_comp(amp);
    v.nx = 16'(x);
    v.ny = 16'(y);
    v.nz = 16'(z);
    r = $sqrt(real'(x) * x + real'(y) * y + real'(z) * z);
    case ($urandom_range(0, 9))
      0:       v.len = 16'd0;
      1:       v.len = 16'($urandom);
      default: v.len = (r > 65535.0) ? 16'hFFFF : 16'(int'(r));
    endcase
    if ($urandom_range(0, 4) == 0) v.strength = 16'($urandom);
    else v.strength = 16'(rand_comp(8192));
    return v;
  endfunction

  function automatic logic signed [15:0] sun_part(real c, real n);
    return 16'(int'(c * 16384.0 / n));
  endfunction

  task automatic random_setting();
    real x, y, z, n;
    if ($urandom_range(0, 3) == 0) begin
      // arbitrary patterns, out-of-range included
      load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 24'($urandom), 16'($urandom));
    end else begin
      n = 0.0;
      while (n < 0.01) begin
        x = real'(rand_comp(1000)) / 1000.0;
        y = real'(rand_comp(1000)) / 1000.0;
        z = real'(rand_comp(1000)) / 1000.0;
        n = $sqrt(x * x + y * y + z * z);
      end
      load_setting(sun_part(x, n), sun_part(y, n), sun_part(z, n),
                   16'(rand_comp(12288)), 16'(rand_comp(12288)), 24'($urandom),
                   16'(rand_comp(4096)));
    end
  endtask

  initial begin
    vertex_t v;
    rst_ni           = 1'b0;
    burst_left       = 0;
    in_valid_i       = 1'b0;
    base_colour_i    = '0;
    normal_x_i       = '0;
    normal_y_i       = '0;
    normal_z_i       = '0;
    normal_length_i  = '0;
    light_strength_i = '0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, under reset defaults (sun points down -y)
    send_vertex('{24'h000000, 16'sd0, -16'sd100, 16'sd0, 16'd100, 16'sd4096});
    send_vertex('{24'hFFFFFF, 16'sd0, -16'sd100, 16'sd0, 16'd100, 16'sd4096});
    send_vertex('{24'hFFFFFF, 16'sd0, 16'sd100, 16'sd0, 16'd100, 16'sd4096});
    send_vertex('{24'h80FF01, 16'sd0, -16'sd100, 16'sd0, 16'd0, 16'sd32767});
    send_vertex('{24'hFFFFFF, 16'sd32767, 16'sd32767, 16'sd32767, 16'd1, 16'sd32767});
    send_vertex('{24'hFFFFFF, -16'sd32768, -16'sd32768, -16'sd32768, 16'd1,
                  -16'sd32768});
    send_vertex('{24'hFFFFFF, 16'sd0, -16'sd32768, 16'sd0, 16'd65535, 16'sd32767});
    send_vertex('{24'hFF00FF, 16'sd0, -16'sd1, 16'sd0, 16'd65535, 16'sd32767});
    send_vertex('{24'h00FF00, 16'sd0, 16'sd1, 16'sd0, 16'd65535, -16'sd32768});
    send_vertex('{24'hFFFFFF, 16'sd0, -16'sd100, 16'sd0, 16'd100, -16'sd4096});
    send_vertex('{24'h123456, 16'sd0, 16'sd100, 16'sd0, 16'd100, -16'sd32768});
    send_vertex('{24'hFFFFFF, 16'sd0, -16'sd3, 16'sd0, 16'd7, 16'sd8192});
    drain();

    // extremes of the gain, tint and ambient registers
    load_setting(16'sd16384, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 24'hFFFFFF,
                 16'sd32767);
    send_vertex('{24'hFFFFFF, 16'sd32767, 16'sd0, 16'sd0, 16'd1, 16'sd32767});
    send_vertex('{24'hFFFFFF, -16'sd32768, 16'sd0, 16'sd0, 16'd1, 16'sd32767});
    send_vertex('{24'h010101, 16'sd100, 16'sd0, 16'sd0, 16'd100, 16'sd4096});
    for (int i = 0; i < 100; i++) send_vertex(make_vertex());
    drain();
    load_setting(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd32768, 16'sd32767,
                 24'h000000, -16'sd32768);
    send_vertex('{24'hFFFFFF, -16'sd32768, -16'sd32768, -16'sd32768, 16'd1,
                  -16'sd32768});
    send_vertex('{24'hFFFFFF, 16'sd32767, 16'sd32767, 16'sd32767, 16'd1, 16'sd32767});
    for (int i = 0; i < 100; i++) send_vertex(make_vertex());
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      random_setting();
      for (int i = 0; i < 100; i++) send_vertex(make_vertex());
      drain();
    end

    if (mismatch_count == 0 && pending_count == 0)
      $display("directional_light_shading_core: match");
    else
      $display("directional_light_shading_core: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/dlsc_pkg.sv
rtl/dlsc_front.sv
rtl/dlsc_div.sv
rtl/dlsc_scale.sv
rtl/dlsc_shade.sv
rtl/directional_light_shading_core.sv
tb/directional_light_shading_core_checker.sv
tb/directional_light_shading_core_tb.sv
